// ===== rtl/core/owtr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package owtr_pkg;

    localparam int TimeW  = 20;
    localparam int TempW  = 12;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 20;

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    localparam logic [CfgIdxW-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PRES_TIMEOUT  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_POST_PRES     = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SLOT          = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_CONV_WAIT     = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_MAX_TEMP      = 3'd5;

    typedef struct packed {
        logic tick;
        logic start_req;
        logic channel;
        logic wait_conversion;
        logic line_level_a;
        logic line_level_b;
    } t_in_item;

    typedef struct packed {
        logic             drive_low_a;
        logic             drive_low_b;
        logic             busy_res;
        logic             done_res;
        logic [TempW-1:0] temperature;
    } t_out_item;

    typedef struct packed {
        logic [9:0]       reset_low_us;
        logic [9:0]       presence_timeout_us;
        logic [9:0]       post_presence_us;
        logic [7:0]       slot_us;
        logic [TimeW-1:0] conversion_wait_us;
        logic [TempW-1:0] max_valid_temp;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/core/one_wire_temperature_reader_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | valid        | ready        | payload
// ---------+--------------+--------------+-------------------------------
// in       | i_in_valid   | o_in_ready   | i_in   (t_in_item)
// out      | o_out_valid  | i_out_ready  | o_out  (t_out_item)
// cfg      | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item per cycle while o_in_ready is high: the sequencer state and the result register update
// at the edge that accepts the item, result shown the cycle after.
// Synchronous active-low reset clears the sequencer, the last valid readings
// and the result valid flag; configuration returns to its defaults.
// o_in_ready drops only while a result is held and i_out_ready is low.
// Configuration writes are always taken and act from the next edge.

module one_wire_temperature_reader_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  owtr_pkg::t_in_item            i_in,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output owtr_pkg::t_out_item           o_out,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [owtr_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire [owtr_pkg::CfgDataW-1:0]  i_cfg_data
);
    import owtr_pkg::*;

    t_cfg      cfg;
    t_out_item res;
    logic      accept;
    logic      r_out_valid;
    t_out_item r_out;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    owtr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    owtr_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= res;
        end
    end

    a_one_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.drive_low_a && r_out.drive_low_b))
        else $error("both lines driven");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done while busy");

    a_temp_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.done_res) |-> (r_out.temperature == '0))
        else $error("temperature without done");

endmodule

`default_nettype wire

// ===== rtl/core/owtr_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owtr_cfg (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [owtr_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  wire [owtr_pkg::CfgDataW-1:0]   i_cfg_data,
    output owtr_pkg::t_cfg                 o_cfg
);
    import owtr_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_us        <= 10'd200;
            r_cfg.presence_timeout_us <= 10'd500;
            r_cfg.post_presence_us    <= 10'd100;
            r_cfg.slot_us             <= 8'd20;
            r_cfg.conversion_wait_us  <= 20'd500000;
            r_cfg.max_valid_temp      <= 12'd99;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RESET_LOW:    r_cfg.reset_low_us        <= i_cfg_data[9:0];
                CFG_PRES_TIMEOUT: r_cfg.presence_timeout_us <= i_cfg_data[9:0];
                CFG_POST_PRES:    r_cfg.post_presence_us    <= i_cfg_data[9:0];
                CFG_SLOT:         r_cfg.slot_us             <= i_cfg_data[7:0];
                CFG_CONV_WAIT:    r_cfg.conversion_wait_us  <= i_cfg_data[TimeW-1:0];
                CFG_MAX_TEMP:     r_cfg.max_valid_temp      <= i_cfg_data[TempW-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/owtr_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owtr_seq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  owtr_pkg::t_in_item   i_item,
    input  owtr_pkg::t_cfg       i_cfg,
    output owtr_pkg::t_out_item  o_res
);
    import owtr_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_RST_LOW, PH_PRES_WAIT, PH_POST_PRES,
        PH_WR_LOW, PH_WR_HOLD, PH_WR_REC, PH_CONV_WAIT,
        PH_RD0_LOW, PH_RD0_REL, PH_RD1_LOW, PH_RD1_REL
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [TimeW-1:0] r_tc, n_tc;
    logic [2:0]       r_bit, n_bit;
    logic [2:0]       r_step, n_step;
    logic [7:0]       r_shift, n_shift;
    logic [15:0]      r_raw, n_raw;
    logic             r_ach, n_ach;
    logic             r_wf, n_wf;
    logic [TempW-1:0] r_last [2];
    logic [TempW-1:0] n_last [2];

    logic [TimeW-1:0] lim;
    logic [TimeW:0]   tc_inc;
    logic             tmr_done;
    logic [TimeW-1:0] tc_next;
    logic             level;

    logic [2:0]       ent_s;
    logic [7:0]       ent_shift_in;
    t_phase           ent_phase;
    logic [2:0]       ent_step;
    logic [7:0]       ent_shift;

    logic [7:0]       samp;
    logic [TempW-1:0] temp;
    logic             done;
    logic             drive;

    assign level  = r_ach ? i_item.line_level_b : i_item.line_level_a;
    assign tc_inc = {1'b0, r_tc} + {{TimeW{1'b0}}, 1'b1};

    always_comb begin
        unique case (r_phase)
            PH_RST_LOW:   lim = {10'd0, i_cfg.reset_low_us};
            PH_PRES_WAIT: lim = {10'd0, i_cfg.presence_timeout_us};
            PH_POST_PRES: lim = {10'd0, i_cfg.post_presence_us};
            PH_WR_HOLD, PH_RD0_REL, PH_RD1_REL: lim = {12'd0, i_cfg.slot_us};
            PH_CONV_WAIT: lim = i_cfg.conversion_wait_us;
            default:      lim = {{(TimeW-1){1'b0}}, 1'b1};
        endcase
    end

    assign tmr_done = tc_inc >= {1'b0, lim};
    assign tc_next  = tmr_done ? '0 : tc_inc[TimeW-1:0];
    assign samp     = (r_tc == '0) ? {level, r_shift[7:1]} : r_shift;

    always_comb begin
        if (r_phase == PH_IDLE) begin
            ent_s = 3'd0;
        end else if (r_phase == PH_CONV_WAIT) begin
            ent_s = 3'd4;
        end else begin
            ent_s = r_step + 3'd1;
        end
        ent_shift_in = (r_phase == PH_WR_REC) ? {1'b0, r_shift[7:1]} : r_shift;
    end

    always_comb begin
        ent_step  = ent_s;
        ent_shift = ent_shift_in;
        unique case (ent_s)
            3'd0, 3'd4: ent_phase = PH_RST_LOW;
            3'd1, 3'd5: begin
                ent_phase = PH_WR_LOW;
                ent_shift = CMD_SKIP_ROM;
            end
            3'd2: begin
                ent_phase = PH_WR_LOW;
                ent_shift = CMD_CONVERT;
            end
            3'd3: begin
                if (r_wf && (i_cfg.conversion_wait_us != '0)) begin
                    ent_phase = PH_CONV_WAIT;
                end else begin
                    ent_phase = PH_RST_LOW;
                    ent_step  = 3'd4;
                end
            end
            3'd6: begin
                ent_phase = PH_WR_LOW;
                ent_shift = CMD_READ_PAD;
            end
            default: begin
                ent_phase = PH_RD0_LOW;
                ent_shift = 8'd0;
            end
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_tc      = r_tc;
        n_bit     = r_bit;
        n_step    = r_step;
        n_shift   = r_shift;
        n_raw     = r_raw;
        n_ach     = r_ach;
        n_wf      = r_wf;
        n_last[0] = r_last[0];
        n_last[1] = r_last[1];
        done      = 1'b0;
        temp      = '0;

        if (r_phase == PH_IDLE) begin
            if (i_item.start_req) begin
                n_ach   = i_item.channel;
                n_wf    = i_item.wait_conversion;
                n_raw   = '0;
                n_phase = ent_phase;
                n_step  = ent_step;
                n_shift = ent_shift;
                n_tc    = '0;
                n_bit   = '0;
            end
        end else if (i_item.tick) begin
            unique case (r_phase)
                PH_RST_LOW: begin
                    n_tc = tc_next;
                    if (tmr_done) n_phase = PH_PRES_WAIT;
                end
                PH_PRES_WAIT: begin
                    if (!level) begin
                        n_tc    = '0;
                        n_phase = PH_POST_PRES;
                    end else begin
                        n_tc = tc_next;
                        if (tmr_done) n_phase = PH_POST_PRES;
                    end
                end
                PH_POST_PRES, PH_CONV_WAIT: begin
                    n_tc = tc_next;
                    if (tmr_done) begin
                        n_phase = ent_phase;
                        n_step  = ent_step;
                        n_shift = ent_shift;
                        n_bit   = '0;
                    end
                end
                PH_WR_LOW: begin
                    n_tc = tc_next;
                    if (tmr_done) n_phase = PH_WR_HOLD;
                end
                PH_WR_HOLD: begin
                    n_tc = tc_next;
                    if (tmr_done) n_phase = PH_WR_REC;
                end
                PH_WR_REC: begin
                    n_tc = tc_next;
                    if (tmr_done) begin
                        if (r_bit == 3'd7) begin
                            n_phase = ent_phase;
                            n_step  = ent_step;
                            n_shift = ent_shift;
                            n_bit   = '0;
                        end else begin
                            n_shift = ent_shift_in;
                            n_bit   = r_bit + 3'd1;
                            n_phase = PH_WR_LOW;
                        end
                    end
                end
                PH_RD0_LOW: begin
                    n_tc = tc_next;
                    if (tmr_done) n_phase = PH_RD0_REL;
                end
                PH_RD1_LOW: begin
                    n_tc = tc_next;
                    if (tmr_done) n_phase = PH_RD1_REL;
                end
                PH_RD0_REL, PH_RD1_REL: begin
                    n_shift = samp;
                    n_tc    = tc_next;
                    if (tmr_done) begin
                        if (r_bit != 3'd7) begin
                            n_bit   = r_bit + 3'd1;
                            n_phase = (r_phase == PH_RD0_REL) ? PH_RD0_LOW : PH_RD1_LOW;
                        end else if (r_phase == PH_RD0_REL) begin
                            n_raw   = {8'd0, samp};
                            n_shift = 8'd0;
                            n_bit   = '0;
                            n_phase = PH_RD1_LOW;
                        end else begin
                            n_raw = {samp, r_raw[7:0]};
                            temp  = samp[7] ? '0 : {samp, r_raw[7:4]};
                            if (temp <= i_cfg.max_valid_temp) begin
                                n_last[r_ach] = temp;
                            end else begin
                                temp = r_last[r_ach];
                            end
                            done    = 1'b1;
                            n_bit   = '0;
                            n_step  = '0;
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        drive = (n_phase == PH_RST_LOW) || (n_phase == PH_WR_LOW) ||
                (n_phase == PH_RD0_LOW) || (n_phase == PH_RD1_LOW) ||
                ((n_phase == PH_WR_HOLD) && !n_shift[0]);
        o_res.drive_low_a = drive && !n_ach;
        o_res.drive_low_b = drive && n_ach;
        o_res.busy_res    = n_phase != PH_IDLE;
        o_res.done_res    = done;
        o_res.temperature = done ? temp : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tc      <= '0;
            r_bit     <= '0;
            r_step    <= '0;
            r_shift   <= '0;
            r_raw     <= '0;
            r_ach     <= 1'b0;
            r_wf      <= 1'b0;
            r_last[0] <= '0;
            r_last[1] <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_tc      <= n_tc;
            r_bit     <= n_bit;
            r_step    <= n_step;
            r_shift   <= n_shift;
            r_raw     <= n_raw;
            r_ach     <= n_ach;
            r_wf      <= n_wf;
            r_last[0] <= n_last[0];
            r_last[1] <= n_last[1];
        end
    end

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (r_phase == PH_IDLE) && !i_item.start_req) |=> (r_phase == PH_IDLE))
        else $error("idle left without start");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> ($stable(r_phase) && $stable(r_tc)))
        else $error("state moved without an item");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_res.done_res) |=> (r_phase == PH_IDLE))
        else $error("done without return to idle");

endmodule

`default_nettype wire

// ===== dv/one_wire_temperature_reader_top_test.sv =====
`timescale 1ns / 1ps

module one_wire_temperature_reader_top_test;

    import owtr_pkg::*;

    typedef enum logic [4:0] {
        SQ_IDLE, SQ_RST_LOW, SQ_PRES_WAIT, SQ_POST_PRES,
        SQ_WR_LOW, SQ_WR_HOLD, SQ_WR_REC, SQ_CONV_WAIT,
        SQ_RD0_LOW, SQ_RD0_REL, SQ_RD1_LOW, SQ_RD1_REL
    } seq_phase_e;

    typedef enum logic [2:0] {
        ST_RESET1, ST_SKIP1, ST_CONVERT, ST_CONV_WAIT,
        ST_RESET2, ST_SKIP2, ST_READ_CMD, ST_READ_BYTES
    } seq_step_e;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idling_e;

    class reading_scoreboard;
        t_cfg        cfg;
        seq_phase_e  phase;
        seq_step_e   step;
        logic [19:0] tcount;
        logic [2:0]  bit_idx;
        logic [7:0]  shreg;
        logic [15:0] raw;
        logic        chan;
        logic        wait_on;
        logic [11:0] last_ok [2];
        t_out_item   expected_outputs [$];
        int          errors;
        int          readings;

        function new();
            cfg = '{reset_low_us: 10'd200, presence_timeout_us: 10'd500,
                    post_presence_us: 10'd100, slot_us: 8'd20,
                    conversion_wait_us: 20'd500000, max_valid_temp: 12'd99};
            phase = SQ_IDLE;
            step = ST_RESET1;
            tcount = '0;
            bit_idx = '0;
            shreg = '0;
            raw = '0;
            chan = 1'b0;
            wait_on = 1'b0;
            last_ok[0] = '0;
            last_ok[1] = '0;
            errors = 0;
            readings = 0;
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                CFG_RESET_LOW: begin
                    cfg.reset_low_us = data[9:0];
                end
                CFG_PRES_TIMEOUT: begin
                    cfg.presence_timeout_us = data[9:0];
                end
                CFG_POST_PRES: begin
                    cfg.post_presence_us = data[9:0];
                end
                CFG_SLOT: begin
                    cfg.slot_us = data[7:0];
                end
                CFG_CONV_WAIT: begin
                    cfg.conversion_wait_us = data[19:0];
                end
                CFG_MAX_TEMP: begin
                    cfg.max_valid_temp = data[11:0];
                end
                default: begin
                end
            endcase
        endfunction

        function bit timer_done(int unsigned limit);
            if (tcount + 1 >= limit) begin
                tcount = '0;
                return 1'b1;
            end
            tcount = tcount + 1'b1;
            return 1'b0;
        endfunction

        function void enter_step(seq_step_e s);
            step = s;
            tcount = '0;
            bit_idx = '0;
            case (s)
                ST_RESET1, ST_RESET2: begin
                    phase = SQ_RST_LOW;
                end
                ST_SKIP1, ST_SKIP2: begin
                    shreg = CMD_SKIP_ROM;
                    phase = SQ_WR_LOW;
                end
                ST_CONVERT: begin
                    shreg = CMD_CONVERT;
                    phase = SQ_WR_LOW;
                end
                ST_CONV_WAIT: begin
                    if (wait_on && cfg.conversion_wait_us != 0) begin
                        phase = SQ_CONV_WAIT;
                    end else begin
                        step = ST_RESET2;
                        phase = SQ_RST_LOW;
                    end
                end
                ST_READ_CMD: begin
                    shreg = CMD_READ_PAD;
                    phase = SQ_WR_LOW;
                end
                default: begin
                    shreg = '0;
                    phase = SQ_RD0_LOW;
                end
            endcase
        endfunction

        function t_out_item predict_line_activity(t_in_item it);
            t_out_item   r;
            logic        level;
            logic        done;
            logic        drive;
            logic [11:0] deg;
            done = 1'b0;
            drive = 1'b0;
            deg = '0;
            if (phase == SQ_IDLE) begin
                if (it.start_req) begin
                    chan = it.channel;
                    wait_on = it.wait_conversion;
                    raw = '0;
                    enter_step(ST_RESET1);
                end
            end else if (it.tick) begin
                level = chan ? it.line_level_b : it.line_level_a;
                case (phase)
                    SQ_RST_LOW: begin
                        if (timer_done(cfg.reset_low_us)) phase = SQ_PRES_WAIT;
                    end
                    SQ_PRES_WAIT: begin
                        if (!level) begin
                            tcount = '0;
                            phase = SQ_POST_PRES;
                        end else if (timer_done(cfg.presence_timeout_us)) begin
                            phase = SQ_POST_PRES;
                        end
                    end
                    SQ_POST_PRES: begin
                        if (timer_done(cfg.post_presence_us)) enter_step(seq_step_e'(step + 1));
                    end
                    SQ_WR_LOW: begin
                        if (timer_done(1)) phase = SQ_WR_HOLD;
                    end
                    SQ_WR_HOLD: begin
                        if (timer_done(cfg.slot_us)) phase = SQ_WR_REC;
                    end
                    SQ_WR_REC: begin
                        if (timer_done(1)) begin
                            shreg = shreg >> 1;
                            if (bit_idx == 3'd7) begin
                                enter_step(seq_step_e'(step + 1));
                            end else begin
                                bit_idx = bit_idx + 1'b1;
                                phase = SQ_WR_LOW;
                            end
                        end
                    end
                    SQ_CONV_WAIT: begin
                        if (timer_done(cfg.conversion_wait_us)) enter_step(ST_RESET2);
                    end
                    SQ_RD0_LOW: begin
                        if (timer_done(1)) phase = SQ_RD0_REL;
                    end
                    SQ_RD1_LOW: begin
                        if (timer_done(1)) phase = SQ_RD1_REL;
                    end
                    SQ_RD0_REL, SQ_RD1_REL: begin
                        if (tcount == 0) shreg = {level, shreg[7:1]};
                        if (timer_done(cfg.slot_us)) begin
                            if (bit_idx != 3'd7) begin
                                bit_idx = bit_idx + 1'b1;
                                phase = (phase == SQ_RD0_REL) ? SQ_RD0_LOW : SQ_RD1_LOW;
                            end else if (phase == SQ_RD0_REL) begin
                                raw = {8'h00, shreg};
                                shreg = '0;
                                bit_idx = '0;
                                phase = SQ_RD1_LOW;
                            end else begin
                                raw = {shreg, raw[7:0]};
                                // sign bit set reads as zero
                                deg = shreg[7] ? 12'd0 : raw[15:4];
                                if (deg <= cfg.max_valid_temp) last_ok[chan] = deg;
                                else deg = last_ok[chan];
                                done = 1'b1;
                                readings++;
                                bit_idx = '0;
                                step = ST_RESET1;
                                phase = SQ_IDLE;
                            end
                        end
                    end
                    default: begin
                        phase = SQ_IDLE;
                    end
                endcase
            end
            if (phase inside {SQ_RST_LOW, SQ_WR_LOW, SQ_RD0_LOW, SQ_RD1_LOW}) drive = 1'b1;
            else if (phase == SQ_WR_HOLD && !shreg[0]) drive = 1'b1;
            r.drive_low_a = !chan && drive;
            r.drive_low_b = chan && drive;
            r.busy_res = (phase != SQ_IDLE);
            r.done_res = done;
            r.temperature = done ? deg : 12'd0;
            return r;
        endfunction

        function void note_line_item(t_in_item it);
            expected_outputs.push_back(predict_line_activity(it));
        endfunction

        function void mismatch(string field, logic [11:0] want, logic [11:0] got);
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        endfunction

        function void check_bus_result(t_out_item got);
            t_out_item want;
            if (expected_outputs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none got %p", $time, got);
                return;
            end
            want = expected_outputs.pop_front();
            if (got.drive_low_a !== want.drive_low_a)
                mismatch("drive_low_a", want.drive_low_a, got.drive_low_a);
            if (got.drive_low_b !== want.drive_low_b)
                mismatch("drive_low_b", want.drive_low_b, got.drive_low_b);
            if (got.busy_res !== want.busy_res)
                mismatch("busy_res", want.busy_res, got.busy_res);
            if (got.done_res !== want.done_res)
                mismatch("done_res", want.done_res, got.done_res);
            if (got.temperature !== want.temperature)
                mismatch("temperature", want.temperature, got.temperature);
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_item            i_in;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_item           o_out;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;

    reading_scoreboard sb;
    int          src_pct;
    int          sink_pct;
    bit          hold_req;
    logic [15:0] sensor_word;

    one_wire_temperature_reader_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_bus_result(o_out);
            if (i_in_valid && o_in_ready) sb.note_line_item(i_in);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 79;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= sink_pct);
            end
        end
    end

    function automatic void set_idling(idling_e m);
        src_pct = (m == IDLE_SRC) ? 65 : (m == IDLE_BOTH) ? 13 : 0;
        sink_pct = (m == IDLE_SINK) ? 65 : (m == IDLE_BOTH) ? 13 : 0;
    endfunction

    function automatic logic [15:0] pick_reading();
        int unsigned lim;
        int unsigned v;
        lim = (sb.cfg.max_valid_temp > 2047) ? 2047 : sb.cfg.max_valid_temp;
        case ($urandom_range(4))
            0: begin
                v = $urandom_range(lim, 0);
                return {1'b0, 11'(v), 4'($urandom)};
            end
            1: begin
                v = (lim < 2047) ? $urandom_range(2047, lim + 1) : $urandom;
                return {1'b0, 11'(v), 4'($urandom)};
            end
            2: return {1'b1, 15'($urandom)};
            3: begin
                case ($urandom_range(3))
                    0: return 16'h0000;
                    1: return 16'h7fff;
                    2: return 16'hffff;
                    default: return 16'h8000;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // sensor-like line levels most of the time, plain noise otherwise
    function automatic t_in_item make_item();
        t_in_item it;
        logic     lvl;
        it.tick = ($urandom_range(99) < 88);
        it.start_req = ($urandom_range(99) < 35);
        it.channel = 1'($urandom);
        it.wait_conversion = 1'($urandom);
        it.line_level_a = 1'($urandom);
        it.line_level_b = 1'($urandom);
        if ($urandom_range(99) < 90) begin
            lvl = 1'($urandom);
            case (sb.phase)
                SQ_PRES_WAIT: lvl = ($urandom_range(99) < 40);
                SQ_RD0_REL:   lvl = sensor_word[sb.bit_idx];
                SQ_RD1_REL:   lvl = sensor_word[8 + sb.bit_idx];
                default: begin
                end
            endcase
            if (sb.chan) it.line_level_b = lvl;
            else it.line_level_a = lvl;
        end
        if (sb.phase == SQ_IDLE && it.start_req) sensor_word = pick_reading();
        return it;
    endfunction

    function automatic t_in_item directed_item(int i);
        t_in_item it;
        logic [3:0] b;
        b = 4'(i);
        case (i)
            0: it = '0;
            1: it = '{tick: 1'b1, start_req: 1'b0, channel: 1'b0, wait_conversion: 1'b0,
                      line_level_a: 1'b1, line_level_b: 1'b1};
            2: it = '{tick: 1'b0, start_req: 1'b1, channel: 1'b1, wait_conversion: 1'b1,
                      line_level_a: 1'b0, line_level_b: 1'b0};
            3: it = '{tick: 1'b1, start_req: 1'b1, channel: 1'b0, wait_conversion: 1'b0,
                      line_level_a: 1'b1, line_level_b: 1'b1};
            default: it = '{tick: 1'b1, start_req: b[2], channel: b[3],
                            wait_conversion: !b[0], line_level_a: b[0], line_level_b: b[1]};
        endcase
        return it;
    endfunction

    task automatic push_item(input bit fixed, input t_in_item given);
        t_in_item it;
        @(negedge i_clk);
        while ($urandom_range(99) < src_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        it = fixed ? given : make_item();
        i_in <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic stop_items();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input t_cfg c);
        while (sb.expected_outputs.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        write_reg(CFG_RESET_LOW, CfgDataW'(c.reset_low_us));
        write_reg(CFG_PRES_TIMEOUT, CfgDataW'(c.presence_timeout_us));
        write_reg(CFG_POST_PRES, CfgDataW'(c.post_presence_us));
        write_reg(CFG_SLOT, CfgDataW'(c.slot_us));
        write_reg(CFG_CONV_WAIT, CfgDataW'(c.conversion_wait_us));
        write_reg(CFG_MAX_TEMP, CfgDataW'(c.max_valid_temp));
    endtask

    task automatic run_random(input int n, input idling_e m);
        set_idling(m);
        repeat (n) push_item(1'b0, '0);
        stop_items();
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        hold_req = 1'b0;
        sensor_word = '0;
        set_idling(IDLE_NONE);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 20; i++) push_item(1'b1, directed_item(i));
        stop_items();

        // zero lengths act as one, no conversion wait, nothing above zero valid
        apply_settings('{10'd0, 10'd0, 10'd0, 8'd0, 20'd0, 12'd0});
        run_random(120, IDLE_NONE);

        apply_settings('{10'd1, 10'd1, 10'd1, 8'd1, 20'd2, 12'd99});
        set_idling(IDLE_SRC);
        push_item(1'b0, '0);
        hold_req = 1'b1;
        run_random(150, IDLE_SRC);

        apply_settings('{10'd2, 10'd3, 10'd1, 8'd2, 20'd0, 12'd4095});
        run_random(150, IDLE_SINK);

        apply_settings('{10'd1023, 10'd1023, 10'd1023, 8'd255, 20'd1048575, 12'd4095});
        run_random(80, IDLE_BOTH);

        apply_settings('{10'd1, 10'd2, 10'd2, 8'd1, 20'd5, 12'd2047});
        run_random(150, IDLE_SRC);

        apply_settings('{10'd1, 10'd1, 10'd1, 8'd1, 20'd1, 12'd150});
        for (int k = 0; k < 80; k++) begin
            if (k % 20 == 0) set_idling(idling_e'((k / 20) % 4));
            push_item(1'b0, '0);
        end
        stop_items();

        while (sb.expected_outputs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== one_wire_temperature_reader_top.f =====
rtl/core/owtr_pkg.sv
rtl/core/owtr_cfg.sv
rtl/core/owtr_seq.sv
rtl/core/one_wire_temperature_reader_top.sv
dv/one_wire_temperature_reader_top_test.sv
